### rtl/bma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DIV
  } bma_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } bma_div_stat_t;

endpackage

`default_nettype wire

### rtl/bma_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bma_in_if #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink   (input valid, input sample, input end_of_block, output ready);
endinterface

interface bma_out_if #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          final_output;

  modport source (output valid, output average, output final_output, input ready);
  modport sink   (input valid, input average, input final_output, output ready);
endinterface

interface bma_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bma_pkg::CFG_W-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

### rtl/bma_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bma_front #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bma_in_if.sink   in_i,
  bma_in_if.source q_o
);

  localparam int DEPTH = bma_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] smp_q [DEPTH];
  logic [DEPTH-1:0]              last_q;
  logic [PTR_W-1:0]              wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]              rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          push, pop;

  assign in_i.ready     = (cnt_q != CNT_W'(DEPTH));
  assign q_o.valid      = (cnt_q != '0);
  assign q_o.sample     = smp_q[rd_ptr_q];
  assign q_o.end_of_block = last_q[rd_ptr_q];

  assign push = in_i.valid & in_i.ready;
  assign pop  = q_o.valid & q_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      smp_q[wr_ptr_q]  <= in_i.sample;
      last_q[wr_ptr_q] <= in_i.end_of_block;
    end
  end

endmodule

`default_nettype wire

### rtl/bma_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, signed dividend, truncates toward zero.
module bma_divider #(
  parameter int SUM_W       = 22,
  parameter int LEN_W       = 7,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       dividend_i,
  input  logic        [LEN_W-1:0]       divisor_i,
  output bma_pkg::bma_div_stat_t        stat_o,
  output logic signed [SAMPLE_BITS-1:0] quotient_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] dvd_q;
  logic [LEN_W-1:0] rem_q;
  logic             neg_q;

  logic [SUM_W-1:0]       mag;
  logic [LEN_W:0]         shifted;
  logic [LEN_W:0]         diff;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] quot_mag;

  assign mag     = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign ge      = (shifted >= {1'b0, divisor_i});
  assign diff    = shifted - {1'b0, divisor_i};

  assign quot_mag   = dvd_q[SAMPLE_BITS-1:0];
  assign quotient_o = neg_q ? -$signed(quot_mag) : $signed(quot_mag);

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag;
      rem_q <= '0;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/bma_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bma_back #(
  parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bma_cfg_if.sink   cfg_i,
  bma_in_if.sink    q_i,
  bma_out_if.source out_o
);

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);

  bma_pkg::bma_state_e state_q, state_d;

  logic        [LEN_W-1:0]       len_q, len_d, len_cfg;
  logic        [ADDR_W-1:0]      wp_q, wp_d, leave_addr;
  logic        [LEN_W-1:0]       fill_q, fill_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d, sum_next;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                          last_q, last_d;
  logic        [LEN_W-1:0]       tail_q, tail_d;
  logic signed [SAMPLE_BITS-1:0] old_q, old_val;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_avg_q, out_avg_d;
  logic                          out_final_q, out_final_d;
  logic                          mem_we, div_start;
  logic        [LEN_W:0]         wp_ext;

  logic signed [SAMPLE_BITS-1:0] mem_q [MAX_WINDOW];

  bma_pkg::bma_div_stat_t        div_stat;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  bma_divider #(
    .SUM_W       (SUM_W),
    .LEN_W       (LEN_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_bma_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_next),
    .divisor_i  (len_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.average      = out_avg_q;
  assign out_o.final_output = out_final_q;

  // Zero length acts as one, oversize saturates.
  always_comb begin
    if (cfg_i.window_length == '0) begin
      len_cfg = LEN_W'(1);
    end else if (32'(cfg_i.window_length) > 32'(MAX_WINDOW)) begin
      len_cfg = LEN_W'(MAX_WINDOW);
    end else begin
      len_cfg = LEN_W'(cfg_i.window_length);
    end
  end

  assign wp_ext     = (LEN_W + 1)'(wp_q);
  assign leave_addr = (wp_ext >= (LEN_W + 1)'(len_q))
                    ? ADDR_W'(wp_ext - (LEN_W + 1)'(len_q))
                    : ADDR_W'(wp_ext + (LEN_W + 1)'(MAX_WINDOW) - (LEN_W + 1)'(len_q));

  // Leaving entry only counts once it was written in this block.
  assign old_val  = (fill_q >= len_q) ? old_q : '0;
  assign sum_next = sum_q + SUM_W'(x_q) - SUM_W'(old_val);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    x_d         = x_q;
    last_d      = last_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_avg_d   = out_avg_q;
    out_final_d = out_final_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    q_i.ready   = 1'b0;

    case (state_q)
      bma_pkg::ST_IDLE: begin
        q_i.ready = 1'b1;
        if (q_i.valid) begin
          x_d     = q_i.sample;
          last_d  = q_i.end_of_block;
          tail_d  = q_i.end_of_block ? len_q - LEN_W'(1) : '0;
          state_d = bma_pkg::ST_READ;
        end
      end
      bma_pkg::ST_READ: begin
        state_d = bma_pkg::ST_ACC;
      end
      bma_pkg::ST_ACC: begin
        sum_d     = sum_next;
        mem_we    = 1'b1;
        wp_d      = (wp_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + ADDR_W'(1);
        fill_d    = (fill_q == LEN_W'(MAX_WINDOW)) ? fill_q : fill_q + LEN_W'(1);
        div_start = 1'b1;
        state_d   = bma_pkg::ST_DIV;
      end
      bma_pkg::ST_DIV: begin
        if (div_stat.done && !div_stat.busy && (!out_valid_q || out_o.ready)) begin
          out_valid_d = 1'b1;
          out_avg_d   = div_quot;
          out_final_d = last_q && (tail_q == '0);
          if (tail_q != '0) begin
            tail_d  = tail_q - LEN_W'(1);
            x_d     = '0;
            state_d = bma_pkg::ST_READ;
          end else begin
            if (last_q) begin
              wp_d   = '0;
              fill_d = '0;
              sum_d  = '0;
            end
            state_d = bma_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bma_pkg::ST_IDLE;
      end
    endcase

    if (cfg_i.valid) begin
      len_d  = len_cfg;
      wp_d   = '0;
      fill_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bma_pkg::ST_IDLE;
      len_q       <= LEN_W'(1);
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      tail_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      tail_q      <= tail_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    out_avg_q   <= out_avg_d;
    out_final_q <= out_final_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bma_pkg::ST_READ) begin
      old_q <= mem_q[leave_addr];
    end
    if (mem_we) begin
      mem_q[wp_q] <= x_q;
    end
  end

endmodule

`default_nettype wire

### rtl/boxcar_moving_average_top.sv
// channel  dir  beat fields                     handshake
// cfg_i    in   window_length [6:0]             valid/ready (ready always high)
// in_i     in   sample [SB-1:0], end_of_block   valid/ready
// out_o    out  average [SB-1:0], final_output  valid/ready
//
// A result passes the queue, then states READ, ACC and DIV, where the bit-serial divider
// works over SUM_W = SAMPLE_BITS + log2(MAX_WINDOW) bits (22 by default).
// Reset is async active low; no clearing pass is needed, the window starts empty.
// A two-entry queue keeps accepting while the back end works; one output register
// holds a result while out_o stalls, and the back end waits on it.
`timescale 1ns / 1ps
`default_nettype none

module boxcar_moving_average_top #(
  parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bma_cfg_if.sink   cfg_i,
  bma_in_if.sink    in_i,
  bma_out_if.source out_o
);

  bma_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) q_if ();

  bma_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_bma_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q_if.source)
  );

  bma_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_bma_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .q_i    (q_if.sink),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### rtl/bma_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bma_checker #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_last_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_average_i,
  input logic                   out_final_i
);

  logic       seen_in_q;
  logic [3:0] fin_pend_q;
  logic       in_last_beat, out_final_beat;

  assign in_last_beat   = in_valid_i & in_ready_i & in_last_i;
  assign out_final_beat = out_valid_i & out_ready_i & out_final_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q  <= 1'b0;
      fin_pend_q <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        seen_in_q <= 1'b1;
      end
      if (in_last_beat && !out_final_beat) begin
        fin_pend_q <= fin_pend_q + 4'd1;
      end else if (out_final_beat && !in_last_beat) begin
        fin_pend_q <= fin_pend_q - 4'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_average_i) && $stable(out_final_i))
    else $error("stalled output beat changed");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_in_q)
    else $error("output beat before any input beat");

  a_final_matches_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_final_i |-> fin_pend_q != 4'd0)
    else $error("final beat without a pending end of block");

endmodule

bind boxcar_moving_average_top bma_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.end_of_block),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_average_i (out_o.average),
  .out_final_i   (out_o.final_output)
);

`default_nettype wire
